// ----- rtl/lns_location_speed_packer_assert.svh -----
// Assertion macros shared by the packer checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef LNS_LOCATION_SPEED_PACKER_ASSERT_SVH
`define LNS_LOCATION_SPEED_PACKER_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define LSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/lsp_pkg.sv -----
// Shared types, constants and helpers of the LNS location/speed packer.
// No dependencies.
package lsp_pkg;

  localparam int unsigned MaxPacketBytes = 28;
  localparam int unsigned AttHeader      = 3;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QueueAw        = $clog2(QueueDepth);
  localparam int unsigned QueueCw        = $clog2(QueueDepth + 1);
  localparam int unsigned LenW           = $clog2(MaxPacketBytes + 1);
  localparam int unsigned FeatW          = 21;
  localparam int unsigned MtuW           = 10;
  localparam int unsigned NumFields      = 7;

  // Configuration register indexes.
  localparam logic [1:0] RegFeature = 2'd0;
  localparam logic [1:0] RegMtu     = 2'd1;

  // Output segments in send order; the flags word is always first.
  localparam logic [2:0] SegFlags = 3'd0;
  localparam logic [2:0] SegSpeed = 3'd1;
  localparam logic [2:0] SegDist  = 3'd2;
  localparam logic [2:0] SegLoc   = 3'd3;
  localparam logic [2:0] SegElev  = 3'd4;
  localparam logic [2:0] SegHead  = 3'd5;
  localparam logic [2:0] SegRoll  = 3'd6;
  localparam logic [2:0] SegUtc   = 3'd7;

  // Classified sample as it waits for serialization.
  typedef struct packed {
    logic [15:0]          flags;
    logic [NumFields-1:0] en;
    logic                 too_long;
    logic [15:0]          speed;
    logic [23:0]          odometer;
    logic signed [31:0]   latitude;
    logic signed [31:0]   longitude;
    logic signed [23:0]   elevation;
    logic [15:0]          heading;
    logic [7:0]           roll_time;
    logic [55:0]          utc_stamp;
  } lsp_item_t;

  // Index of the final byte of a segment.
  function automatic logic [2:0] seg_last_idx(input logic [2:0] seg);
    logic [2:0] r;
    unique case (seg)
      SegFlags: r = 3'd1;
      SegSpeed: r = 3'd1;
      SegDist:  r = 3'd2;
      SegLoc:   r = 3'd7;
      SegElev:  r = 3'd2;
      SegHead:  r = 3'd1;
      SegRoll:  r = 3'd0;
      SegUtc:   r = 3'd6;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/lns_location_speed_packer.sv -----
// First byte: a sample accepted into an empty queue is stored in the queue, then loaded into the output register.
// Throughput: one byte per cycle while out_ready_i is high; a packet is 2 to 28 bytes long,
//   or a single zero byte when the sample is rejected as too long.
// The two-entry queue lets new samples enter while earlier packets are still streaming.
// Reset (async, active low) empties the queue and output, clears the feature word, MTU to 23.
module lns_location_speed_packer import lsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [FeatW-1:0]    cfg_data_i,
  // sample channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         sample_flags_i,
  input  logic [15:0]         speed_i,
  input  logic [23:0]         odometer_i,
  input  logic signed [31:0]  latitude_i,
  input  logic signed [31:0]  longitude_i,
  input  logic signed [23:0]  elevation_i,
  input  logic [15:0]         heading_i,
  input  logic [7:0]          roll_time_i,
  input  logic [55:0]         utc_stamp_i,
  // byte channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_byte_o,
  output logic                last_byte_o,
  output logic                too_long_o
);

  // Only the seven field enables of the feature word have any effect, so
  // hold just those; the upper feature bits are accepted and dropped.
  logic [NumFields-1:0] feat_q;
  logic [MtuW-1:0]      mtu_q;

  lsp_item_t front_item;
  lsp_item_t head_item;
  logic      head_valid;
  logic      pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_q <= '0;
      mtu_q  <= MtuW'(23);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFeature: feat_q <= cfg_data_i[NumFields-1:0];
        RegMtu:     mtu_q  <= cfg_data_i[MtuW-1:0];
        default:    ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front: classify the incoming sample in the cycle it arrives.
  lsp_front u_front (
    .feat_i         (feat_q),
    .mtu_i          (mtu_q),
    .sample_flags_i (sample_flags_i),
    .speed_i        (speed_i),
    .odometer_i     (odometer_i),
    .latitude_i     (latitude_i),
    .longitude_i    (longitude_i),
    .elevation_i    (elevation_i),
    .heading_i      (heading_i),
    .roll_time_i    (roll_time_i),
    .utc_stamp_i    (utc_stamp_i),
    .item_o         (front_item)
  );

  // Queue: decouple acceptance from byte streaming.
  lsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .ready_o (in_ready_o),
    .valid_o (head_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  // Back: stream the head packet byte by byte, pop after its last byte.
  lsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_byte_o  (data_byte_o),
    .last_byte_o  (last_byte_o),
    .too_long_o   (too_long_o)
  );

endmodule

// ----- rtl/lsp_queue.sv -----
// Two-entry item queue between the classifier and the serializer.
// Depends on lsp_pkg.
module lsp_queue import lsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lsp_item_t item_i,
  output logic      ready_o,
  output logic      valid_o,
  output lsp_item_t item_o,
  input  logic      pop_i
);

  lsp_item_t                mem_q [QueueDepth];
  logic [QueueAw-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QueueCw-1:0]       cnt_q, cnt_d;
  logic                     do_push, do_pop;

  assign ready_o = (cnt_q != QueueCw'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/lsp_front.sv -----
// Sample classifier: field selection, flags word, length and MTU check.
// Depends on lsp_pkg.
module lsp_front import lsp_pkg::*; (
  input  logic [NumFields-1:0] feat_i,
  input  logic [MtuW-1:0]      mtu_i,
  input  logic [15:0]          sample_flags_i,
  input  logic [15:0]          speed_i,
  input  logic [23:0]          odometer_i,
  input  logic signed [31:0]   latitude_i,
  input  logic signed [31:0]   longitude_i,
  input  logic signed [23:0]   elevation_i,
  input  logic [15:0]          heading_i,
  input  logic [7:0]           roll_time_i,
  input  logic [55:0]          utc_stamp_i,
  output lsp_item_t            item_o
);

  logic [NumFields-1:0] en;
  logic [15:0]          fl;
  logic [LenW-1:0]      len;
  logic [MtuW:0]        need;

  always_comb begin
    en = feat_i & sample_flags_i[NumFields-1:0];

    // Copy status and source bits only alongside their field.
    fl = {9'd0, en};
    if (en[2]) fl[8:7]   = sample_flags_i[8:7];
    if (en[0] || en[1]) fl[9] = sample_flags_i[9];
    if (en[3]) fl[11:10] = sample_flags_i[11:10];
    if (en[4]) fl[12]    = sample_flags_i[12];

    len = LenW'(2)
        + (en[0] ? LenW'(2) : '0) + (en[1] ? LenW'(3) : '0)
        + (en[2] ? LenW'(8) : '0) + (en[3] ? LenW'(3) : '0)
        + (en[4] ? LenW'(2) : '0) + (en[5] ? LenW'(1) : '0)
        + (en[6] ? LenW'(7) : '0);
    need = (MtuW+1)'(len) + (MtuW+1)'(AttHeader);

    item_o.flags     = fl;
    item_o.en        = en;
    item_o.too_long  = (len > LenW'(MaxPacketBytes)) || (need > {1'b0, mtu_i});
    item_o.speed     = speed_i;
    item_o.odometer  = odometer_i;
    item_o.latitude  = latitude_i;
    item_o.longitude = longitude_i;
    item_o.elevation = elevation_i;
    item_o.heading   = heading_i;
    item_o.roll_time = roll_time_i;
    item_o.utc_stamp = utc_stamp_i;
  end

endmodule

// ----- rtl/lsp_back.sv -----
// Byte serializer: walks the enabled segments of the queue head.
// Depends on lsp_pkg.
module lsp_back import lsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  lsp_item_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [7:0] data_byte_o,
  output logic      last_byte_o,
  output logic      too_long_o
);

  logic [2:0]  seg_q, seg_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  data_q;
  logic        last_q, too_long_q;

  logic        emit, seg_end, nxt_found, last;
  logic [2:0]  nxt_seg;
  logic [63:0] seg_val;
  logic [7:0]  cur_byte;

  always_comb begin
    unique case (seg_q)
      SegFlags: seg_val = {48'd0, head_i.flags};
      SegSpeed: seg_val = {48'd0, head_i.speed};
      SegDist:  seg_val = {40'd0, head_i.odometer};
      SegLoc:   seg_val = {head_i.longitude, head_i.latitude};
      SegElev:  seg_val = {40'd0, head_i.elevation};
      SegHead:  seg_val = {48'd0, head_i.heading};
      SegRoll:  seg_val = {56'd0, head_i.roll_time};
      SegUtc:   seg_val = {8'd0, head_i.utc_stamp};
      default:  seg_val = '0;
    endcase
    cur_byte = seg_val[{cnt_q, 3'b000} +: 8];
  end

  // Next enabled segment after the current one.
  always_comb begin
    nxt_found = 1'b0;
    nxt_seg   = SegFlags;
    for (int i = NumFields; i >= 1; i--) begin
      if (head_i.en[i-1] && (3'(i) > seg_q)) begin
        nxt_found = 1'b1;
        nxt_seg   = 3'(i);
      end
    end
  end

  always_comb begin
    emit    = head_valid_i && (!out_valid_q || out_ready_i);
    seg_end = (cnt_q == seg_last_idx(seg_q));
    last    = head_i.too_long || (seg_end && !nxt_found);
    pop_o   = emit && last;

    seg_d = seg_q;
    cnt_d = cnt_q;
    if (emit) begin
      if (last) begin
        seg_d = SegFlags;
        cnt_d = '0;
      end else if (seg_end) begin
        seg_d = nxt_seg;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SegFlags;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q     <= head_i.too_long ? 8'd0 : cur_byte;
      last_q     <= last;
      too_long_q <= head_i.too_long;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;
  assign last_byte_o = last_q;
  assign too_long_o  = too_long_q;

endmodule

// ----- rtl/lsp_checker.sv -----
// Port-level checks of the packer, bound to the top level.
// Depends on lns_location_speed_packer_assert.svh.
`include "lns_location_speed_packer_assert.svh"

module lsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] data_byte_o,
  input logic       last_byte_o,
  input logic       too_long_o
);

  // An error result stands alone: last and zero.
  `LSP_ASSERT(a_err_alone, out_valid_o && too_long_o |-> last_byte_o && (data_byte_o == 8'd0), "error result not a lone zero last byte")

  // Inside a packet no error result may follow.
  `LSP_ASSERT(a_no_err_mid, out_valid_o && out_ready_i && !last_byte_o |=> !too_long_o, "error result inside a packet")

  // A stalled byte holds.
  `LSP_ASSERT(a_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o), "stalled byte changed")

  // Nothing is offered as reset releases.
  `LSP_ASSERT_RST(a_rst_quiet, $rose(rst_ni) |-> !out_valid_o, "output valid at reset release")

endmodule

bind lns_location_speed_packer lsp_checker u_lsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_byte_o (data_byte_o),
  .last_byte_o (last_byte_o),
  .too_long_o  (too_long_o)
);
